// ----- src/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared types and constants of the byte histogram sorter.
// ----------------------------------------------------------------------------
package bhs_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int SYMBOLS_DEF    = 256;
   localparam int SYM_W          = 8;
   localparam int OUT_CNT_W      = 32;
   localparam int DIST_W         = 9;

   localparam logic [1:0] FUNC_COUNT  = 2'd0;
   localparam logic [1:0] FUNC_FINISH = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_COUNT,
      OP_SWAP,
      OP_ROTATE,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic             phase;
      logic [SYM_W-1:0] byte_val;
   } cell_ctl_type;

endpackage

// ----- src/bhs_cell.sv -----
// ----------------------------------------------------------------------------
// bhs_cell
// One slot of the sorting chain: holds a symbol and its counter, counts its
// own symbol, compare-exchanges with a neighbor, shifts along the ring or clears.
// ----------------------------------------------------------------------------
module bhs_cell #(
   parameter int COUNT_BITS = 32,
   parameter int SYMBOLS    = 256,
   parameter int INDEX      = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bhs_pkg::cell_ctl_type      ctl,
   input  logic [bhs_pkg::SYM_W-1:0]  left_sym,
   input  logic [COUNT_BITS-1:0]      left_cnt,
   input  logic [bhs_pkg::SYM_W-1:0]  right_sym,
   input  logic [COUNT_BITS-1:0]      right_cnt,
   output logic [bhs_pkg::SYM_W-1:0]  sym,
   output logic [COUNT_BITS-1:0]      cnt
);
   import bhs_pkg::*;

   localparam logic PAR   = (INDEX % 2) != 0;
   localparam logic HAS_R = (INDEX + 1) < SYMBOLS;
   localparam logic HAS_L = INDEX > 0;
   localparam logic [SYM_W-1:0] INIT_SYM = INDEX[SYM_W-1:0];

   logic [SYM_W-1:0]      sym_ff, sym_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  right_first, self_first;

   // ordering: larger count first, ties by smaller symbol
   assign right_first = (right_cnt > cnt_ff) ||
                        ((right_cnt == cnt_ff) && (right_sym < sym_ff));
   assign self_first  = (cnt_ff > left_cnt) ||
                        ((cnt_ff == left_cnt) && (sym_ff < left_sym));

   always_comb begin
      sym_in = sym_ff;
      cnt_in = cnt_ff;
      unique case (ctl.op)
         OP_COUNT: begin
            if ((sym_ff == ctl.byte_val) && (cnt_ff != {COUNT_BITS{1'b1}})) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_SWAP: begin
            if ((ctl.phase == PAR) && HAS_R) begin
               if (right_first) begin
                  sym_in = right_sym;
                  cnt_in = right_cnt;
               end
            end else if ((ctl.phase != PAR) && HAS_L) begin
               if (self_first) begin
                  sym_in = left_sym;
                  cnt_in = left_cnt;
               end
            end
         end
         OP_ROTATE: begin
            sym_in = right_sym;
            cnt_in = right_cnt;
         end
         OP_CLEAR: begin
            sym_in = INIT_SYM;
            cnt_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= INIT_SYM;
         cnt_ff <= '0;
      end else begin
         sym_ff <= sym_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sym = sym_ff;
   assign cnt = cnt_ff;

endmodule

// ----- src/byte_histogram_sort_core.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_sort_core
// Byte frequency counter with ranked readout, built as a ring of cells.
// ----------------------------------------------------------------------------
// count and clear requests: one per cycle while the core is idle, no response.
// finish request: odd-even transposition sort of the ring, then rotating the ring
//   to tally nonzero counts; the response is registered in S_WAIT, and the next
//   request is taken once the response is loaded (a stalled response holds it).
// read request: one full rotation, capturing the requested rank; response as for finish.
// reset: synchronous; counters zero, identity order, distinct count zero.
module byte_histogram_sort_core
   import bhs_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int SYMBOLS    = SYMBOLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // data_byte[7:0], rank[15:8]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // symbol[7:0], count[39:8], distinct[48:40],
                                   // nonzero[49], zero[55:50]
);
   localparam int CNT_W = $clog2(SYMBOLS + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(SYMBOLS - 1);

   typedef enum logic [2:0] {S_IDLE, S_SORT, S_TALLY, S_READ, S_WAIT} state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       step_ff;
   logic                   phase_ff;
   logic [SYM_W-1:0]       rank_ff;
   logic [DIST_W-1:0]      distinct_ff, tally_ff;
   logic [SYM_W-1:0]       cap_sym_ff;
   logic [OUT_CNT_W-1:0]   cap_cnt_ff;
   logic                   rsp_valid_ff;
   logic [55:0]            rsp_data_ff;
   logic                   finish_ff;
   logic                   rsp_load;

   cell_ctl_type           ctl;
   logic [SYM_W-1:0]       sym_w [SYMBOLS];
   logic [COUNT_BITS-1:0]  cnt_w [SYMBOLS];
   logic [OUT_CNT_W-1:0]   head_cnt;
   logic                   accept;

   genvar g;
   generate
      for (g = 0; g < SYMBOLS; g++) begin : g_cell
         bhs_cell #(
            .COUNT_BITS(COUNT_BITS),
            .SYMBOLS   (SYMBOLS),
            .INDEX     (g)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .left_sym (sym_w[(g + SYMBOLS - 1) % SYMBOLS]),
            .left_cnt (cnt_w[(g + SYMBOLS - 1) % SYMBOLS]),
            .right_sym(sym_w[(g + 1) % SYMBOLS]),
            .right_cnt(cnt_w[(g + 1) % SYMBOLS]),
            .sym      (sym_w[g]),
            .cnt      (cnt_w[g])
         );
      end
      if (COUNT_BITS > OUT_CNT_W) begin : g_sat
         assign head_cnt = (|cnt_w[0][COUNT_BITS-1:OUT_CNT_W]) ? '1
                                                                : cnt_w[0][OUT_CNT_W-1:0];
      end else if (COUNT_BITS == OUT_CNT_W) begin : g_eq
         assign head_cnt = cnt_w[0];
      end else begin : g_ext
         assign head_cnt = {{(OUT_CNT_W - COUNT_BITS){1'b0}}, cnt_w[0]};
      end
   endgenerate

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_WAIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctl.op       = OP_HOLD;
      ctl.phase    = phase_ff;
      ctl.byte_val = req_tdata[7:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  FUNC_COUNT: ctl.op = OP_COUNT;
                  FUNC_CLEAR: ctl.op = OP_CLEAR;
                  default:    ctl.op = OP_HOLD;
               endcase
            end
         end
         S_SORT:           ctl.op = OP_SWAP;
         S_TALLY, S_READ:  ctl.op = OP_ROTATE;
         default:          ctl.op = OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         distinct_ff  <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  step_ff    <= '0;
                  phase_ff   <= 1'b0;
                  rank_ff    <= req_tdata[15:8];
                  cap_sym_ff <= '0;
                  cap_cnt_ff <= '0;
                  tally_ff   <= '0;
                  unique case (req_tuser)
                     FUNC_FINISH: state_ff <= S_SORT;
                     FUNC_READ:   state_ff <= S_READ;
                     FUNC_CLEAR:  distinct_ff <= '0;
                     default:     state_ff <= S_IDLE;
                  endcase
               end
            end
            S_SORT: begin
               phase_ff <= ~phase_ff;
               step_ff  <= step_ff + 1'b1;
               if (step_ff == LAST) begin
                  step_ff  <= '0;
                  state_ff <= S_TALLY;
               end
            end
            S_TALLY: begin
               tally_ff <= tally_ff + DIST_W'(head_cnt != '0);
               step_ff  <= step_ff + 1'b1;
               if (step_ff == LAST) begin
                  state_ff <= S_WAIT;
               end
            end
            S_READ: begin
               if (step_ff == {1'b0, rank_ff}) begin
                  cap_sym_ff <= sym_w[0];
                  cap_cnt_ff <= head_cnt;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST) begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
                  if (finish_ff) begin
                     distinct_ff <= tally_ff;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // response payload and finish bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         finish_ff <= 1'b0;
      end else if (accept) begin
         finish_ff <= (req_tuser == FUNC_FINISH);
      end
   end

   logic [DIST_W-1:0] dist_out;
   assign dist_out = finish_ff ? tally_ff : distinct_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (finish_ff) begin
            rsp_data_ff <= {6'd0, 1'b0, dist_out, {OUT_CNT_W{1'b0}}, {SYM_W{1'b0}}};
         end else begin
            rsp_data_ff <= {6'd0, (cap_cnt_ff != '0), dist_out, cap_cnt_ff, cap_sym_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- sim/byte_histogram_sort_core_tb.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_sort_core_tb
// Self-checking bench: counts bytes, sorts, reads ranks and clears, comparing
// every response with an internal histogram and sort model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module byte_histogram_sort_core_tb;
   import bhs_pkg::*;

   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic [7:0] rank;
   } req_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic [31:0] count;
      logic [8:0]  distinct;
      logic        nonzero;
   } rsp_type;

   typedef struct {
      req_type req;
      logic    known;
      rsp_type rsp;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   // histogram model
   logic [31:0] hist_count [256];
   logic [7:0]  rank_order [256];
   logic [8:0]  nonzero_syms;

   rsp_type     rsp_queue [$];
   rsp_type     typed_queue [$];
   logic        typed_flag [$];
   int          errors;
   int          idle_cycles;
   int          n_requests;
   int          n_responses;
   bit          no_idle;

   byte_histogram_sort_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit ranks_ahead(int a, int b);
      if (hist_count[a] != hist_count[b]) return hist_count[a] > hist_count[b];
      return a < b;
   endfunction

   function automatic void histogram_clear();
      for (int i = 0; i < 256; i++) begin
         hist_count[i] = '0;
         rank_order[i] = i[7:0];
      end
      nonzero_syms = '0;
   endfunction

   // returns 1 and fills the response when the request produces one
   function automatic bit histogram_apply(req_type r, output rsp_type o);
      int   j;
      int   nz;
      logic [7:0] s;
      o = '0;
      case (r.func)
         FUNC_COUNT: begin
            if (hist_count[r.data_byte] != 32'hFFFF_FFFF)
               hist_count[r.data_byte]++;
            return 1'b0;
         end
         FUNC_FINISH: begin
            for (int i = 0; i < 256; i++) rank_order[i] = i[7:0];
            for (int i = 1; i < 256; i++) begin
               s = rank_order[i];
               j = i;
               while (j > 0 && ranks_ahead(s, rank_order[j-1])) begin
                  rank_order[j] = rank_order[j-1];
                  j--;
               end
               rank_order[j] = s;
            end
            nz = 0;
            for (int i = 0; i < 256; i++) if (hist_count[i] != 0) nz++;
            nonzero_syms = nz[8:0];
            o.distinct   = nonzero_syms;
            return 1'b1;
         end
         FUNC_READ: begin
            o.symbol   = rank_order[r.rank];
            o.count    = hist_count[o.symbol];
            o.nonzero  = o.count != 0;
            o.distinct = nonzero_syms;
            return 1'b1;
         end
         default: begin
            histogram_clear();
            return 1'b0;
         end
      endcase
   endfunction

   // waits out idle gaps, then holds the request until accepted
   task automatic send_request(req_type r, logic known, rsp_type typed);
      rsp_type o;
      while (!no_idle && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.rank, r.data_byte};
      req_tuser  <= r.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (histogram_apply(r, o)) begin
         rsp_queue.push_back(o);
         typed_queue.push_back(typed);
         typed_flag.push_back(known);
      end
      n_requests++;
      @(negedge clock);
   endtask

   function automatic req_type mk(logic [1:0] f, logic [7:0] b, logic [7:0] k);
      req_type r;
      r.func = f;
      r.data_byte = b;
      r.rank = k;
      return r;
   endfunction

   function automatic rsp_type rs(logic [7:0] s, logic [31:0] c, logic [8:0] d,
                                  logic n);
      rsp_type o;
      o.symbol = s;
      o.count = c;
      o.distinct = d;
      o.nonzero = n;
      return o;
   endfunction

   // response checker and ready driver
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      logic    known;
      rsp_type typed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{symbol: rsp_tdata[7:0], count: rsp_tdata[39:8],
                 distinct: rsp_tdata[48:40], nonzero: rsp_tdata[49]};
         n_responses++;
         if (rsp_queue.size() == 0) begin
            $error("response with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want  = rsp_queue.pop_front();
            typed = typed_queue.pop_front();
            known = typed_flag.pop_front();
            if (known && typed != want) begin
               $error("table row disagrees with model");
               errors++;
            end
            if (got.symbol != want.symbol) begin
               $error("symbol: expected %0d, got %0d", want.symbol, got.symbol);
               errors++;
            end
            if (got.count != want.count) begin
               $error("count: expected %0d, got %0d", want.count, got.count);
               errors++;
            end
            if (got.distinct != want.distinct) begin
               $error("distinct: expected %0d, got %0d", want.distinct,
                      got.distinct);
               errors++;
            end
            if (got.nonzero != want.nonzero) begin
               $error("nonzero: expected %0d, got %0d", want.nonzero,
                      got.nonzero);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= no_idle || ($urandom_range(99) >= 13);
   end

   // watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("timeout with %0d responses outstanding", rsp_queue.size());
         $display("CHECK FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      row_type table_rows [$];
      req_type r;
      int      pick;
      int      hot;
      errors = 0;
      n_requests = 0;
      n_responses = 0;
      idle_cycles = 0;
      no_idle = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_COUNT;
      reset = 1'b1;
      histogram_clear();

      // directed table
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd0), 1'b1,
                             rs(8'd0, 32'd0, 9'd0, 1'b0)});
      table_rows.push_back('{mk(FUNC_READ, 8'hFF, 8'd255), 1'b1,
                             rs(8'd255, 32'd0, 9'd0, 1'b0)});
      table_rows.push_back('{mk(FUNC_FINISH, 8'hAA, 8'h55), 1'b1,
                             rs(8'd0, 32'd0, 9'd0, 1'b0)});
      table_rows.push_back('{mk(FUNC_COUNT, 8'hFF, 8'hFF), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'hFF, 8'h00), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'h80, 8'h00), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'h00, 8'h00), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'h7F, 8'h00), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'h80, 8'h00), 1'b0, '0});
      // read before finish: order still identity, count live
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd128), 1'b1,
                             rs(8'd128, 32'd2, 9'd0, 1'b1)});
      table_rows.push_back('{mk(FUNC_FINISH, 8'h00, 8'h00), 1'b1,
                             rs(8'd0, 32'd0, 9'd4, 1'b0)});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd0), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd1), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd2), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd3), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd4), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_COUNT, 8'h01, 8'h00), 1'b0, '0});
      // counting after finish shows in count but not in the order
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd4), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd255), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_CLEAR, 8'hFF, 8'hFF), 1'b0, '0});
      table_rows.push_back('{mk(FUNC_READ, 8'h00, 8'd0), 1'b1,
                             rs(8'd0, 32'd0, 9'd0, 1'b0)});
      table_rows.push_back('{mk(FUNC_FINISH, 8'h00, 8'h00), 1'b1,
                             rs(8'd0, 32'd0, 9'd0, 1'b0)});

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (table_rows[i])
         send_request(table_rows[i].req, table_rows[i].known, table_rows[i].rsp);

      // random part: mostly skewed-byte counts among finishes, reads and clears
      for (int k = 0; k < 450; k++) begin
         no_idle = (k >= 150 && k < 230);
         pick = $urandom_range(99);
         hot  = $urandom_range(7);
         if (pick < 62)
            r = mk(FUNC_COUNT, ($urandom_range(1) ? hot[7:0] << $urandom_range(5)
                                                  : 8'($urandom)), 8'($urandom));
         else if (pick < 70)
            r = mk(FUNC_FINISH, 8'($urandom), 8'($urandom));
         else if (pick < 97)
            r = mk(FUNC_READ, 8'($urandom),
                   $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom));
         else
            r = mk(FUNC_CLEAR, 8'($urandom), 8'($urandom));
         send_request(r, 1'b0, '0);
      end
      r = mk(FUNC_FINISH, 8'h00, 8'h00);
      send_request(r, 1'b0, '0);
      r = mk(FUNC_READ, 8'h00, 8'd0);
      send_request(r, 1'b0, '0);
      req_tvalid <= 1'b0;
      no_idle = 1'b0;

      while (rsp_queue.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("sent %0d requests, checked %0d responses (count/finish/read/clear)",
               n_requests, n_responses);
      if (errors == 0 && rsp_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
